// File: src/pixel_color_adjust_pack_defines.svh
// Assertion macros for the pixel color adjust block.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef PIXEL_COLOR_ADJUST_PACK_DEFINES_SVH
`define PIXEL_COLOR_ADJUST_PACK_DEFINES_SVH

// same-cycle implication
`define PCA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pixel_color_adjust_pack: same-cycle check failed");

// next-cycle implication
`define PCA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pixel_color_adjust_pack: next-cycle check failed");

`endif

// File: src/pca_pkg.sv
// Shared types, constants and helpers for the pixel color adjust block.
// No dependencies.
package pca_pkg;

	localparam int CH_W      = 16;
	localparam int GT_DEPTH  = 32768;
	localparam int GT_AW     = $clog2(GT_DEPTH);
	localparam int GT_DW     = 15;
	localparam int NSTG      = 10;   // stages ahead of the output register
	localparam int NLANE     = 3;

	// register indexes on the config port
	localparam logic [2:0] REG_ADJUST_ENABLE  = 3'd0;
	localparam logic [2:0] REG_SATURATION_PCT = 3'd1;
	localparam logic [2:0] REG_GAMMA_ENABLE   = 3'd2;
	localparam logic [2:0] REG_LUMINANCE_PCT  = 3'd3;
	localparam logic [2:0] REG_PIXEL_DEPTH    = 3'd4;

	localparam logic [1:0] DEPTH_NONE = 2'd0;
	localparam logic [1:0] DEPTH_8888 = 2'd1;
	localparam logic [1:0] DEPTH_2101010 = 2'd2;

	// floor(x/3) = (x*M3) >> 20 for x < 2^18
	localparam logic [18:0] MUL_DIV3   = 19'd349526;
	localparam int          SH_DIV3    = 20;
	// floor(x/100) = (x*M100) >> 32 for x < 2^25
	localparam logic [25:0] MUL_DIV100 = 26'd42949673;
	localparam int          SH_DIV100  = 32;

	typedef struct packed {
		logic [NSTG:1] ce;   // load enable per stage
	} ctl_t;

	typedef struct packed {
		logic [7:0] sat_pct;
		logic [6:0] sat_inv;  // max(0, 100 - sat)
		logic       sat_byp;
		logic       gam_on;
		logic [6:0] lum_pct;
		logic       lum_byp;
	} lane_cfg_t;

	typedef struct packed {
		logic             en;
		logic [GT_AW-1:0] idx;
		logic [GT_DW-1:0] val;
	} tw_t;

	typedef struct packed {
		logic             func;
		logic [CH_W-1:0]  alpha;
		logic [GT_AW-1:0] tidx;
		logic [GT_DW-1:0] tval;
	} meta_t;

	function automatic logic [CH_W-1:0] sat16(input logic [17:0] v);
		return (v > 18'd65535) ? 16'hFFFF : v[CH_W-1:0];
	endfunction

endpackage

// File: src/pca_gray.sv
// Shared gray term: truncated average of the three channels.
// Depends on pca_pkg.
module pca_gray (
	input  logic           clk,
	input  pca_pkg::ctl_t  ctl,
	input  logic [17:0]    sum_s1,
	output logic [15:0]    gray_s2
);
	import pca_pkg::*;

	logic [36:0] gp_s2;

	always_ff @(posedge clk) begin
		if (ctl.ce[2]) begin
			gp_s2 <= 37'(sum_s1) * 37'(MUL_DIV3);
		end
	end

	assign gray_s2 = gp_s2[SH_DIV3+15:SH_DIV3];

endmodule

// File: src/pca_lane.sv
// One color channel lane: saturation, gamma lookup, luminance.
// Holds its own copy of the gamma table. Depends on pca_pkg.
module pca_lane (
	input  logic               clk,
	input  pca_pkg::ctl_t      ctl,
	input  pca_pkg::lane_cfg_t cfg,
	input  pca_pkg::tw_t       tw,
	input  logic [15:0]        ch_s1,
	input  logic [15:0]        gray_s2,
	output logic [15:0]        res_s10
);
	import pca_pkg::*;

	logic [GT_DW-1:0] mem [GT_DEPTH];

	logic [15:0] ch_s2, ch_s3, ch_s4, ch_s5;
	logic [23:0] mc_s3;
	logic [22:0] mg_s3;
	logic [23:0] x_s4;
	logic [49:0] qp_s5;
	logic [15:0] sc_s6, sc_s7;
	logic [GT_DW-1:0] rd_s7;
	logic [15:0] gc;
	logic [15:0] gc_s8, gc_s9;
	logic [22:0] lp_s8;
	logic [48:0] lq_s9;
	logic [15:0] sat_c;

	// saturation mix
	always_ff @(posedge clk) begin
		if (ctl.ce[2]) ch_s2 <= ch_s1;
		if (ctl.ce[3]) begin
			ch_s3 <= ch_s2;
			mc_s3 <= 24'(ch_s2) * 24'(cfg.sat_pct);
			mg_s3 <= 23'(gray_s2) * 23'(cfg.sat_inv);
		end
		if (ctl.ce[4]) begin
			ch_s4 <= ch_s3;
			x_s4  <= mc_s3 + 24'(mg_s3);
		end
		if (ctl.ce[5]) begin
			ch_s5 <= ch_s4;
			qp_s5 <= 50'(x_s4) * 50'(MUL_DIV100);
		end
	end

	assign sat_c = cfg.sat_byp ? ch_s5 : sat16(qp_s5[SH_DIV100+17:SH_DIV100]);

	always_ff @(posedge clk) begin
		if (ctl.ce[6]) sc_s6 <= sat_c;
	end

	// gamma table: written by table transactions, read as a pixel enters stage 7
	always_ff @(posedge clk) begin
		if (tw.en) mem[tw.idx] <= tw.val;
		if (ctl.ce[7]) begin
			rd_s7 <= mem[sc_s6[GT_AW-1:0]];
			sc_s7 <= sc_s6;
		end
	end

	assign gc = (cfg.gam_on && !sc_s7[15]) ? {1'b0, rd_s7} : sc_s7;

	// luminance scale
	always_ff @(posedge clk) begin
		if (ctl.ce[8]) begin
			gc_s8 <= gc;
			lp_s8 <= 23'(gc) * 23'(cfg.lum_pct);
		end
		if (ctl.ce[9]) begin
			gc_s9 <= gc_s8;
			lq_s9 <= 49'(lp_s8) * 49'(MUL_DIV100);
		end
		if (ctl.ce[10]) begin
			res_s10 <= cfg.lum_byp ? gc_s9
				: sat16({1'b0, lq_s9[SH_DIV100+16:SH_DIV100]});
		end
	end

endmodule

// File: src/pca_pack.sv
// Merge stage: packs alpha and the three lane results into one word (zero for other depth codes).
// Depends on pca_pkg.
module pca_pack (
	input  logic        clk,
	input  logic        load,
	input  logic [1:0]  depth,
	input  logic [15:0] alpha_s10,
	input  logic [15:0] r_s10,
	input  logic [15:0] g_s10,
	input  logic [15:0] b_s10,
	output logic [31:0] color_q
);
	import pca_pkg::*;

	logic [31:0] packed_c;

	always_comb begin
		case (depth)
			DEPTH_2101010: packed_c = {alpha_s10[15:14], r_s10[15:6], g_s10[15:6],
				b_s10[15:6]};
			DEPTH_8888:    packed_c = {alpha_s10[15:8], r_s10[15:8], g_s10[15:8],
				b_s10[15:8]};
			default:       packed_c = 32'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) color_q <= packed_c;
	end

endmodule

// File: src/pixel_color_adjust_pack.sv
// Top level of the pixel color adjust block: config registers, pipeline
// control and the lane array. Depends on pca_pkg, pca_gray, pca_lane, pca_pack.
//
// Takes one transaction per clock and returns one packed pixel per clock while
// the output is not held by a low out_ready: a pixel transaction (func 0)
// yields exactly one color transaction, through ten pipeline stages plus the
// output register; a gamma table write (func 1) uses a slot, yields nothing. The
// three color channels run in three identical lanes; the slowest path in each
// is one 24x26 reciprocal multiply that replaces the divide by 100. Each lane
// keeps a private copy of the 32768-entry gamma table, so three lookups happen
// in the same cycle; every table write goes to all copies at once, in order
// with the pixels around it. Each stage moves on its own when the stage ahead
// is empty or moving, so bubbles close up and input fills any empty stages while
// a finished color waits in the output register. Table entries never written
// read back as whatever the RAM holds. Config writes are taken at any time
// but must only happen while the pipeline is empty.
`include "pixel_color_adjust_pack_defines.svh"

module pixel_color_adjust_pack (
	input  logic        clk,
	input  logic        arst_n,
	// pixel / table transaction in
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        func,
	input  logic [15:0] alpha,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic [14:0] table_index,
	input  logic [14:0] table_value,
	// packed color out
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] color,
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import pca_pkg::*;

	// config registers
	logic       adjust_enable_q;
	logic [7:0] saturation_pct_q;
	logic       gamma_enable_q;
	logic [6:0] luminance_pct_q;
	logic [1:0] pixel_depth_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			adjust_enable_q  <= 1'b1;
			saturation_pct_q <= 8'd100;
			gamma_enable_q   <= 1'b0;
			luminance_pct_q  <= 7'd100;
			pixel_depth_q    <= DEPTH_8888;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ADJUST_ENABLE:  adjust_enable_q  <= cfg_data[0];
				REG_SATURATION_PCT: saturation_pct_q <= cfg_data;
				REG_GAMMA_ENABLE:   gamma_enable_q   <= cfg_data[0];
				REG_LUMINANCE_PCT:  luminance_pct_q  <= cfg_data[6:0];
				REG_PIXEL_DEPTH:    pixel_depth_q    <= cfg_data[1:0];
				default: ;  // indexes past the list are dropped
			endcase
		end
	end

	// lane settings: user must keep static while traffic is flowing; not enforced
	lane_cfg_t lcfg;
	always_comb begin
		lcfg.sat_pct = saturation_pct_q;
		lcfg.sat_inv = (saturation_pct_q < 8'd100) ? 7'(8'd100 - saturation_pct_q) : 7'd0;
		lcfg.sat_byp = !adjust_enable_q || (saturation_pct_q == 8'd100);
		lcfg.gam_on  = adjust_enable_q && gamma_enable_q;
		lcfg.lum_pct = luminance_pct_q;
		lcfg.lum_byp = !adjust_enable_q || (luminance_pct_q == 7'd100);
	end

	// pipeline occupancy and per-stage load enables
	logic [NSTG:1]   vld_q;
	logic            out_vld_q;
	logic [NSTG+1:1] can;   // stage may load this cycle
	ctl_t            ctl;

	always_comb begin
		can[NSTG+1] = !out_vld_q || out_ready;
		for (int i = NSTG; i >= 1; i--) begin
			can[i] = !vld_q[i] || can[i+1];
		end
		ctl.ce = can[NSTG:1];
	end

	assign in_ready  = can[1];
	assign out_valid = out_vld_q;

	// per-transaction side data, indexed by stage
	meta_t meta_s [1:NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (can[1]) vld_q[1] <= in_valid;
			for (int i = 2; i <= NSTG; i++) begin
				if (can[i]) vld_q[i] <= vld_q[i-1];
			end
			// table writes die here: only pixels reach the output
			if (can[NSTG+1]) out_vld_q <= vld_q[NSTG] && !meta_s[NSTG].func;
		end
	end

	logic [15:0] ch_s1 [NLANE];
	logic [17:0] sum_s1;

	always_ff @(posedge clk) begin
		if (can[1]) begin
			meta_s[1].func  <= func;
			meta_s[1].alpha <= alpha;
			meta_s[1].tidx  <= table_index;
			meta_s[1].tval  <= table_value;
			ch_s1[0] <= red;
			ch_s1[1] <= green;
			ch_s1[2] <= blue;
			sum_s1   <= 18'(red) + 18'(green) + 18'(blue);
		end
		for (int i = 2; i <= NSTG; i++) begin
			if (can[i]) meta_s[i] <= meta_s[i-1];
		end
	end

	// table write lands in every lane copy as the transaction enters stage 7,
	// the same point at which pixels read the table
	tw_t tw;
	assign tw.en  = can[7] && vld_q[6] && meta_s[6].func;
	assign tw.idx = meta_s[6].tidx;
	assign tw.val = meta_s[6].tval;

	logic [15:0] gray_s2;
	logic [15:0] res_s10 [NLANE];

	pca_gray u_gray (
		.clk     (clk),
		.ctl     (ctl),
		.sum_s1  (sum_s1),
		.gray_s2 (gray_s2)
	);

	for (genvar l = 0; l < NLANE; l++) begin : g_lane
		pca_lane u_lane (
			.clk     (clk),
			.ctl     (ctl),
			.cfg     (lcfg),
			.tw      (tw),
			.ch_s1   (ch_s1[l]),
			.gray_s2 (gray_s2),
			.res_s10 (res_s10[l])
		);
	end

	pca_pack u_pack (
		.clk       (clk),
		.load      (can[NSTG+1]),
		.depth     (pixel_depth_q),
		.alpha_s10 (meta_s[NSTG].alpha),
		.r_s10     (res_s10[0]),
		.g_s10     (res_s10[1]),
		.b_s10     (res_s10[2]),
		.color_q   (color)
	);

	// a table write leaving the last stage never shows up as a color
	`PCA_ASSERT_NEXT(a_tw_no_out, vld_q[NSTG] && meta_s[NSTG].func && can[NSTG+1], !out_valid)
	// an accepted transaction always occupies stage 1 next cycle
	`PCA_ASSERT_NEXT(a_in_lands, in_valid && in_ready, vld_q[1])
	// a held output blocks the last stage, which then keeps its transaction
	`PCA_ASSERT_NOW(a_stall_back, out_valid && !out_ready && vld_q[NSTG], !ctl.ce[NSTG])

endmodule
